### rtl/core/usage_hour_and_filament_meter_assert.svh
// Assertion macros shared by the usage meter RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef USAGE_HOUR_AND_FILAMENT_METER_ASSERT_SVH
`define USAGE_HOUR_AND_FILAMENT_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UHFM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uhfm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define UHFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uhfm assertion failed");

`endif

### rtl/core/uhfm_pkg.sv
// Shared constants, types and helper functions of the usage meter.
// No dependencies; every RTL module of the block and the bench import it.
`timescale 1ns / 1ps

package uhfm_pkg;

   // Default fraction bits of the mm fixed-point registers
   localparam int FRAC_BITS_DEF = 8;

   // Field widths
   localparam int NUM_METERS = 6;
   localparam int FLOW_W     = 16;
   localparam int FLOW_FRAC  = 12;
   localparam int Q_W        = 24;
   localparam int DIFF_W     = Q_W;
   localparam int ADD_W      = DIFF_W + FLOW_W - FLOW_FRAC;
   localparam int XW         = ADD_W;
   localparam int MW         = XW + 2;
   localparam int LW         = 5;
   localparam int PROD_W     = XW + MW;
   localparam int DIV_STEPS  = XW + Q_W;
   localparam int CNT_W      = 6;

   // Request commands
   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_TRIP    = 2'd1;
   localparam logic [1:0] CMD_RESTORE = 2'd2;
   localparam logic [1:0] CMD_INIT    = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_MINUTE = 2'd0;
   localparam logic [1:0] REG_SAVE   = 2'd1;
   localparam logic [1:0] REG_LIMIT  = 2'd2;
   localparam logic [1:0] REG_UNIT   = 2'd3;

   // Meter slots
   localparam int M_LIFE_MIN  = 0;
   localparam int M_LIFE_PMIN = 1;
   localparam int M_LIFE_LEN  = 2;
   localparam int M_TRIP_MIN  = 3;
   localparam int M_TRIP_PMIN = 4;
   localparam int M_TRIP_LEN  = 5;

   // Register reset values
   localparam logic [31:0] MINUTE_PERIOD_RST = 32'd60000;
   localparam logic [31:0] SAVE_PERIOD_RST   = 32'd3600000;
   localparam int unsigned LIMIT_MM          = 1800;
   localparam int unsigned UNIT_MM           = 10;

   // Control that travels with one request down the pipeline
   typedef struct packed {
      logic [1:0]  cmd;
      logic        fire_m;
      logic        print_inc;
      logic        printing;
      logic        save;
      logic [2:0]  idx;
      logic [31:0] load;
   } uhfm_ctl_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [31:0]    minute_period;
      logic [31:0]    save_period;
      logic [Q_W-1:0] limit;
      logic [MW-1:0]  recip;
      logic [LW-1:0]  shift;
      logic           busy;
   } uhfm_cfg_type;

   // mm value to fixed point, saturated to the register width
   function automatic logic [Q_W-1:0] q_default(input int unsigned mm,
                                                input int unsigned frac);
      logic [47:0] v;
      v = 48'(mm) << frac;
      if (v > 48'(24'hFFFFFF)) return 24'hFFFFFF;
      return v[Q_W-1:0];
   endfunction

   // Smallest l with 2**l >= d
   function automatic logic [LW-1:0] ceil_log2_q(input logic [Q_W-1:0] d);
      logic [LW-1:0] l;
      l = LW'(Q_W);
      for (int i = Q_W; i >= 0; i--) begin
         if ((25'd1 << i) >= {1'b0, d}) l = LW'(i);
      end
      return l;
   endfunction

endpackage

### rtl/core/uhfm_if.sv
// Request and response channel interfaces of the usage meter.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface uhfm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [31:0]        now_ms;
   logic signed [31:0] extruder_pos;
   logic [15:0]        flow_scale;
   logic               busy_req;
   logic [2:0]         counter_index;
   logic [31:0]        load_value;

   modport source (output valid, cmd, now_ms, extruder_pos, flow_scale, busy_req,
                   counter_index, load_value, input ready);
   modport sink (input valid, cmd, now_ms, extruder_pos, flow_scale, busy_req,
                 counter_index, load_value, output ready);
endinterface

interface uhfm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] life_minutes;
   logic [31:0] life_print_minutes;
   logic [31:0] life_print_length;
   logic [31:0] trip_minutes;
   logic [31:0] trip_print_minutes;
   logic [31:0] trip_print_length;
   logic        printing;
   logic        save_request;

   modport source (output valid, life_minutes, life_print_minutes, life_print_length,
                   trip_minutes, trip_print_minutes, trip_print_length, printing,
                   save_request, input ready);
   modport sink (input valid, life_minutes, life_print_minutes, life_print_length,
                 trip_minutes, trip_print_minutes, trip_print_length, printing,
                 save_request, output ready);
endinterface

### rtl/core/uhfm_csr.sv
// APB register file plus the bit-serial reciprocal unit for the length unit.
// Depends on uhfm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "usage_hour_and_filament_meter_assert.svh"

module uhfm_csr
   import uhfm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready,
   output uhfm_cfg_type cfg
);

   localparam logic [Q_W-1:0] LIMIT_RST  = q_default(LIMIT_MM, FRAC_BITS);
   localparam logic [Q_W-1:0] UNIT_RST   = q_default(UNIT_MM, FRAC_BITS);
   localparam logic [Q_W-1:0] UNIT_RST_D = (UNIT_RST == '0) ? Q_W'(1) : UNIT_RST;
   localparam logic [LW-1:0]  UNIT_RST_L = ceil_log2_q(UNIT_RST_D);

   logic [31:0]      minute_ff, save_ff;
   logic [Q_W-1:0]   limit_ff, unit_ff;
   logic [Q_W-1:0]   d_ff, d_new;
   logic [LW-1:0]    l_ff, l_new;
   logic [Q_W-1:0]   rem_ff, rem_in;
   logic [MW-1:0]    q_ff, q_in;
   logic [MW-1:0]    recip_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             wr_w;
   logic [1:0]       reg_idx;
   logic             bit_in;
   logic [Q_W:0]     cat_w;
   logic             ge_w;

   assign pready  = 1'b1;
   assign wr_w    = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // Read back the selected register
   always_comb begin
      case (reg_idx)
         REG_MINUTE: prdata = minute_ff;
         REG_SAVE:   prdata = save_ff;
         REG_LIMIT:  prdata = {8'd0, limit_ff};
         REG_UNIT:   prdata = {8'd0, unit_ff};
         default:    prdata = '0;
      endcase
   end

   // Divisor for a new length unit: zero acts as one
   always_comb begin
      d_new = (pwdata[Q_W-1:0] == '0) ? Q_W'(1) : pwdata[Q_W-1:0];
      l_new = ceil_log2_q(d_new);
   end

   // One restoring step of (2**(XW+l) - 1) / d per cycle, dividend MSB first
   always_comb begin
      bit_in = cnt_ff < (CNT_W'(XW) + CNT_W'(l_ff));
      cat_w  = {rem_ff, bit_in};
      ge_w   = cat_w >= {1'b0, d_ff};
      rem_in = ge_w ? Q_W'(cat_w - {1'b0, d_ff}) : cat_w[Q_W-1:0];
      q_in   = {q_ff[MW-2:0], ge_w};
   end

   // Hold the registers; restart the reciprocal on reset and unit writes
   always_ff @(posedge clock) begin
      if (reset) begin
         minute_ff <= MINUTE_PERIOD_RST;
         save_ff   <= SAVE_PERIOD_RST;
         limit_ff  <= LIMIT_RST;
         unit_ff   <= UNIT_RST;
         d_ff      <= UNIT_RST_D;
         l_ff      <= UNIT_RST_L;
         rem_ff    <= '0;
         q_ff      <= '0;
         cnt_ff    <= CNT_W'(DIV_STEPS - 1);
         busy_ff   <= 1'b1;
      end else begin
         if (wr_w) begin
            case (reg_idx)
               REG_MINUTE: minute_ff <= pwdata;
               REG_SAVE:   save_ff   <= pwdata;
               REG_LIMIT:  limit_ff  <= pwdata[Q_W-1:0];
               REG_UNIT:   unit_ff   <= pwdata[Q_W-1:0];
               default:    ;
            endcase
         end
         if (wr_w && reg_idx == REG_UNIT) begin
            d_ff    <= d_new;
            l_ff    <= l_new;
            rem_ff  <= '0;
            q_ff    <= '0;
            cnt_ff  <= CNT_W'(DIV_STEPS - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Round the quotient up on the last step
   always_ff @(posedge clock) begin
      if (busy_ff && cnt_ff == '0) recip_ff <= q_in + MW'(1);
   end

   assign cfg.minute_period = minute_ff;
   assign cfg.save_period   = save_ff;
   assign cfg.limit         = limit_ff;
   assign cfg.recip         = recip_ff;
   assign cfg.shift         = l_ff;
   assign cfg.busy          = busy_ff;

   `UHFM_ASSERT_NEXT(a_recip_start, wr_w && reg_idx == REG_UNIT, busy_ff)

endmodule

### rtl/core/uhfm_track.sv
// Input register and timing state: deadlines, printing flag, last position.
// Depends on uhfm_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "usage_hour_and_filament_meter_assert.svh"

module uhfm_track
   import uhfm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   uhfm_req_if.sink            req_chan,
   input  uhfm_cfg_type        cfg,
   output logic                dn_valid,
   input  logic                dn_ready,
   output uhfm_ctl_type        dn_ctl,
   output logic [DIFF_W-1:0]   dn_diff,
   output logic [FLOW_W-1:0]   dn_flow
);

   // Input register
   logic              v1_ff, v1_in;
   logic [1:0]        cmd_ff;
   logic [31:0]       now_ff, pos_ff, load_ff;
   logic [FLOW_W-1:0] flow_ff;
   logic              busy_ff;
   logic [2:0]        idx_ff;

   // Timing state
   logic [31:0] md_ff, md_in, sd_ff, sd_in, last_ff, last_in;
   logic        prt_ff, prt_in;

   // Second stage
   logic              v2_ff, v2_in;
   uhfm_ctl_type      ctl2_ff, ctl_in;
   logic [DIFF_W-1:0] diff2_ff, diff_in;
   logic [FLOW_W-1:0] flow2_ff;

   logic        acc_w, p2_free, adv1;
   logic        fire_m, fire_s, len_ok;
   logic [32:0] diff_w;

   // Handshake down the first two stages
   assign p2_free        = !v2_ff || dn_ready;
   assign adv1           = v1_ff && p2_free;
   assign req_chan.ready = (!v1_ff || p2_free) && !cfg.busy;
   assign acc_w          = req_chan.valid && req_chan.ready;
   assign v1_in          = acc_w ? 1'b1 : (adv1 ? 1'b0 : v1_ff);
   assign v2_in          = adv1 ? 1'b1 : (dn_ready ? 1'b0 : v2_ff);

   // Deadlines, extrusion delta and printing flag for the held request
   always_comb begin
      md_in   = md_ff;
      sd_in   = sd_ff;
      last_in = last_ff;
      prt_in  = prt_ff;
      diff_in = '0;
      fire_m  = md_ff < now_ff;
      fire_s  = sd_ff < now_ff;
      diff_w  = {pos_ff[31], pos_ff} - {last_ff[31], last_ff};
      len_ok  = !diff_w[32] && (diff_w != '0) && (diff_w < {9'd0, cfg.limit});
      ctl_in.cmd       = cmd_ff;
      ctl_in.fire_m    = 1'b0;
      ctl_in.print_inc = 1'b0;
      ctl_in.printing  = prt_ff;
      ctl_in.save      = 1'b0;
      ctl_in.idx       = idx_ff;
      ctl_in.load      = load_ff;
      case (cmd_ff)
         CMD_SAMPLE: begin
            if (fire_m) begin
               md_in            = md_ff + cfg.minute_period;
               ctl_in.fire_m    = 1'b1;
               ctl_in.print_inc = prt_ff;
               if (prt_ff) begin
                  last_in = pos_ff;
                  if (len_ok) diff_in = diff_w[DIFF_W-1:0];
               end
               // The accumulator is always empty while printing, since
               // entering print mode clears it; only the delta matters.
               if (busy_ff) begin
                  prt_in  = 1'b1;
                  last_in = pos_ff;
               end else begin
                  if (prt_ff) ctl_in.save = 1'b1;
                  prt_in = 1'b0;
               end
            end
            if (fire_s) begin
               sd_in       = now_ff + cfg.save_period;
               ctl_in.save = 1'b1;
            end
            ctl_in.printing = prt_in;
         end
         CMD_INIT: begin
            sd_in           = now_ff + cfg.save_period;
            md_in           = now_ff + cfg.minute_period;
            prt_in          = 1'b0;
            last_in         = pos_ff;
            ctl_in.printing = 1'b0;
         end
         default: ;
      endcase
   end

   // Advance control and timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         md_ff   <= '0;
         sd_ff   <= '0;
         last_ff <= '0;
         prt_ff  <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         if (adv1) begin
            md_ff   <= md_in;
            sd_ff   <= sd_in;
            last_ff <= last_in;
            prt_ff  <= prt_in;
         end
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (acc_w) begin
         cmd_ff  <= req_chan.cmd;
         now_ff  <= req_chan.now_ms;
         pos_ff  <= req_chan.extruder_pos;
         flow_ff <= req_chan.flow_scale;
         busy_ff <= req_chan.busy_req;
         idx_ff  <= req_chan.counter_index;
         load_ff <= req_chan.load_value;
      end
      if (adv1) begin
         ctl2_ff  <= ctl_in;
         diff2_ff <= diff_in;
         flow2_ff <= flow_ff;
      end
   end

   assign dn_valid = v2_ff;
   assign dn_ctl   = ctl2_ff;
   assign dn_diff  = diff2_ff;
   assign dn_flow  = flow2_ff;

   `UHFM_ASSERT_NEXT(a_init_idle, adv1 && cmd_ff == CMD_INIT, !prt_ff)

endmodule

### rtl/core/uhfm_length.sv
// Length datapath: flow-scaled delta, then multiply by the unit reciprocal.
// Depends on uhfm_pkg.
`timescale 1ns / 1ps

module uhfm_length
   import uhfm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  uhfm_cfg_type       cfg,
   input  logic               up_valid,
   output logic               up_ready,
   input  uhfm_ctl_type       up_ctl,
   input  logic [DIFF_W-1:0]  up_diff,
   input  logic [FLOW_W-1:0]  up_flow,
   output logic               dn_valid,
   input  logic               dn_ready,
   output uhfm_ctl_type       dn_ctl,
   output logic [PROD_W-1:0]  dn_prod,
   output logic               dn_nz
);

   localparam int MUL_W = DIFF_W + FLOW_W;

   logic              v3_ff, v3_in, v4_ff, v4_in;
   uhfm_ctl_type      ctl3_ff, ctl4_ff;
   logic [ADD_W-1:0]  add3_ff, add_in;
   logic [PROD_W-1:0] prod4_ff, prod_in;
   logic              nz4_ff;
   logic [MUL_W-1:0]  mul_w;
   logic [XW-1:0]     x_w;
   logic              p4_free, p3_free, adv3, adv2;

   // Handshake
   assign p4_free  = !v4_ff || dn_ready;
   assign adv3     = v3_ff && p4_free;
   assign p3_free  = !v3_ff || p4_free;
   assign adv2     = up_valid && p3_free;
   assign up_ready = p3_free;
   assign v3_in    = adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_ff);
   assign v4_in    = adv3 ? 1'b1 : (dn_ready ? 1'b0 : v4_ff);

   // Scale the delta by the 4.12 flow multiplier, drop the flow fraction
   always_comb begin
      mul_w  = MUL_W'(up_diff) * MUL_W'(up_flow);
      add_in = mul_w[MUL_W-1:FLOW_FRAC];
   end

   // Whole units: floor((add - 1) / unit) via the exact reciprocal
   always_comb begin
      x_w     = add3_ff - XW'(1);
      prod_in = PROD_W'(x_w) * PROD_W'(cfg.recip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         ctl3_ff <= up_ctl;
         add3_ff <= add_in;
      end
      if (adv3) begin
         ctl4_ff  <= ctl3_ff;
         prod4_ff <= prod_in;
         nz4_ff   <= add3_ff != '0;
      end
   end

   assign dn_valid = v4_ff;
   assign dn_ctl   = ctl4_ff;
   assign dn_prod  = prod4_ff;
   assign dn_nz    = nz4_ff;

endmodule

### rtl/core/uhfm_meters.sv
// The six usage meters and the response register.
// Depends on uhfm_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "usage_hour_and_filament_meter_assert.svh"

module uhfm_meters
   import uhfm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  uhfm_cfg_type       cfg,
   input  logic               up_valid,
   output logic               up_ready,
   input  uhfm_ctl_type       up_ctl,
   input  logic [PROD_W-1:0]  up_prod,
   input  logic               up_nz,
   uhfm_rsp_if.source         rsp_chan
);

   logic [31:0]       meters_ff [NUM_METERS];
   logic [31:0]       meters_in [NUM_METERS];
   logic              vo_ff, vo_in;
   logic              prt_ff, save_ff;
   logic              take;
   logic [CNT_W-1:0]  shamt;
   logic [PROD_W-1:0] shifted;
   logic [XW-1:0]     n_w;

   assign up_ready = !vo_ff || rsp_chan.ready;
   assign take     = up_valid && up_ready;
   assign vo_in    = take ? 1'b1 : (rsp_chan.ready ? 1'b0 : vo_ff);

   // Length count from the reciprocal product
   always_comb begin
      shamt   = CNT_W'(XW) + CNT_W'(cfg.shift);
      shifted = up_prod >> shamt;
      n_w     = up_nz ? shifted[XW-1:0] : '0;
   end

   // Apply the request to the meters
   always_comb begin
      for (int k = 0; k < NUM_METERS; k++) meters_in[k] = meters_ff[k];
      case (up_ctl.cmd)
         CMD_SAMPLE: begin
            if (up_ctl.fire_m) begin
               meters_in[M_LIFE_MIN] = meters_ff[M_LIFE_MIN] + 32'd1;
               meters_in[M_TRIP_MIN] = meters_ff[M_TRIP_MIN] + 32'd1;
               if (up_ctl.print_inc) begin
                  meters_in[M_LIFE_PMIN] = meters_ff[M_LIFE_PMIN] + 32'd1;
                  meters_in[M_TRIP_PMIN] = meters_ff[M_TRIP_PMIN] + 32'd1;
                  meters_in[M_LIFE_LEN]  = meters_ff[M_LIFE_LEN] + 32'(n_w);
                  meters_in[M_TRIP_LEN]  = meters_ff[M_TRIP_LEN] + 32'(n_w);
               end
            end
         end
         CMD_TRIP: begin
            meters_in[M_TRIP_MIN]  = '0;
            meters_in[M_TRIP_PMIN] = '0;
            meters_in[M_TRIP_LEN]  = '0;
         end
         CMD_RESTORE: begin
            // Out-of-range indexes match no slot and are dropped
            for (int k = 0; k < NUM_METERS; k++) begin
               if (up_ctl.idx == 3'(k)) meters_in[k] = up_ctl.load;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
         for (int k = 0; k < NUM_METERS; k++) meters_ff[k] <= '0;
      end else begin
         vo_ff <= vo_in;
         if (take) begin
            for (int k = 0; k < NUM_METERS; k++) meters_ff[k] <= meters_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prt_ff  <= up_ctl.printing;
         save_ff <= up_ctl.save;
      end
   end

   assign rsp_chan.valid              = vo_ff;
   assign rsp_chan.life_minutes       = meters_ff[M_LIFE_MIN];
   assign rsp_chan.life_print_minutes = meters_ff[M_LIFE_PMIN];
   assign rsp_chan.life_print_length  = meters_ff[M_LIFE_LEN];
   assign rsp_chan.trip_minutes       = meters_ff[M_TRIP_MIN];
   assign rsp_chan.trip_print_minutes = meters_ff[M_TRIP_PMIN];
   assign rsp_chan.trip_print_length  = meters_ff[M_TRIP_LEN];
   assign rsp_chan.printing           = prt_ff;
   assign rsp_chan.save_request       = save_ff;

   `UHFM_ASSERT_NEXT(a_trip_clear, take && up_ctl.cmd == CMD_TRIP, meters_ff[M_TRIP_MIN] == '0 && meters_ff[M_TRIP_PMIN] == '0 && meters_ff[M_TRIP_LEN] == '0)
   `UHFM_ASSERT_NEXT(a_life_hold, !take, $stable(meters_ff[M_LIFE_MIN]) && $stable(meters_ff[M_LIFE_PMIN]) && $stable(meters_ff[M_LIFE_LEN]))
   `UHFM_ASSERT_NOW(a_rsp_after_take, take, up_ready)

endmodule

### rtl/core/usage_hour_and_filament_meter.sv
// Usage hour and filament meter, top level.
// Requests arrive on req_chan (valid/ready): a time sample, a trip reset, a
// meter restore or an initialise. Every request yields exactly one response
// on rsp_chan carrying all six meters, the printing flag and save_request.
// Registers are written over the APB port (psel/penable/pwrite, pready tied
// high) at byte addresses 0, 4, 8 and 12.
// Throughput: one request per cycle while responses are taken and no
// reciprocal pass runs; the pipeline is input register, timing stage, flow
// multiply, reciprocal multiply and the meter/response register.
// The length count divides by length_unit_q8 through a reciprocal computed
// by a bit-serial divider; req ready stays low during that pass, which
// runs after reset and after each write of length_unit_q8.
// Reset (synchronous, active high) clears meters, deadlines, last position
// and printing flag, and loads the register defaults.
// A stalled response holds its payload; requests keep filling empty pipeline
// stages and ready drops only once every stage is occupied.
`timescale 1ns / 1ps

module usage_hour_and_filament_meter
   import uhfm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   uhfm_req_if.sink    req_chan,
   uhfm_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   uhfm_cfg_type      cfg;
   logic              trk_valid, trk_ready;
   uhfm_ctl_type      trk_ctl;
   logic [DIFF_W-1:0] trk_diff;
   logic [FLOW_W-1:0] trk_flow;
   logic              len_valid, len_ready;
   uhfm_ctl_type      len_ctl;
   logic [PROD_W-1:0] len_prod;
   logic              len_nz;

   uhfm_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   uhfm_track u_track (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .dn_valid (trk_valid),
      .dn_ready (trk_ready),
      .dn_ctl   (trk_ctl),
      .dn_diff  (trk_diff),
      .dn_flow  (trk_flow)
   );

   uhfm_length u_length (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (trk_valid),
      .up_ready (trk_ready),
      .up_ctl   (trk_ctl),
      .up_diff  (trk_diff),
      .up_flow  (trk_flow),
      .dn_valid (len_valid),
      .dn_ready (len_ready),
      .dn_ctl   (len_ctl),
      .dn_prod  (len_prod),
      .dn_nz    (len_nz)
   );

   uhfm_meters u_meters (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (len_valid),
      .up_ready (len_ready),
      .up_ctl   (len_ctl),
      .up_prod  (len_prod),
      .up_nz    (len_nz),
      .rsp_chan (rsp_chan)
   );

endmodule

### bench/tb.sv
// Self-checking bench for the usage hour and filament meter.
// Uses uhfm_pkg, the request/response interfaces and the top-level RTL only;
// a local model of the meters predicts every response.
`timescale 1ns / 1ps

module tb;
   import uhfm_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          HOLD_AT = 250;
   localparam int          HOLD_LEN = 300;
   localparam logic [15:0] FLOW_ONE = 16'h1000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now_ms;
      logic [31:0] extruder_pos;
      logic [15:0] flow_scale;
      logic        busy_req;
      logic [2:0]  counter_index;
      logic [31:0] load_value;
   } meter_req_t;

   typedef struct packed {
      logic [31:0] life_min;
      logic [31:0] life_pmin;
      logic [31:0] life_len;
      logic [31:0] trip_min;
      logic [31:0] trip_pmin;
      logic [31:0] trip_len;
      logic        printing;
      logic        save_request;
   } meter_reading_t;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   uhfm_req_if req_chan();
   uhfm_rsp_if rsp_chan();

   usage_hour_and_filament_meter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Register copies
   logic [31:0] min_period;
   logic [31:0] save_period;
   logic [23:0] limit_q;
   logic [23:0] unit_q;

   // Meter state copies
   logic [31:0] minute_dl;
   logic [31:0] save_dl;
   logic [31:0] last_pos;
   logic [23:0] len_accum;
   logic        printing_st;
   logic [31:0] meter_val [NUM_METERS];

   meter_req_t     pending_reqs[$];
   meter_reading_t reading_q[$];
   meter_req_t     cur_req;
   meter_reading_t exp_reading;

   logic [31:0] gen_time;
   logic [31:0] gen_pos;
   int          fail_count;
   int          rsp_count;
   int          cycle_count;
   int          burst_left;
   int          gap_left;
   int          hold_left;
   bit          hold_done;
   int          stall_mode;
   int          mode_left;

   // Clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Apply one request to the meter copy and queue the response it yields
   task automatic advance_meters(input meter_req_t r);
      meter_reading_t     rd;
      logic signed [32:0] diff;
      logic [63:0]        acc;
      logic [63:0]        unit_eff;
      logic [63:0]        n;
      logic               save;
      save = 1'b0;
      case (r.cmd)
         CMD_SAMPLE: begin
            if (minute_dl < r.now_ms) begin
               minute_dl = minute_dl + min_period;
               meter_val[M_LIFE_MIN]++;
               meter_val[M_TRIP_MIN]++;
               if (printing_st) begin
                  meter_val[M_LIFE_PMIN]++;
                  meter_val[M_TRIP_PMIN]++;
                  diff = {r.extruder_pos[31], r.extruder_pos} - {last_pos[31], last_pos};
                  if (diff > 0 && diff < $signed({9'd0, limit_q})) begin
                     unit_eff = (unit_q == 24'd0) ? 64'd1 : 64'(unit_q);
                     acc = 64'(len_accum) +
                           ((64'(diff[31:0]) * 64'(r.flow_scale)) >> FLOW_FRAC);
                     if (acc > unit_eff) begin
                        n = (acc - 64'd1) / unit_eff;
                        acc = acc - n * unit_eff;
                        meter_val[M_LIFE_LEN] = meter_val[M_LIFE_LEN] + n[31:0];
                        meter_val[M_TRIP_LEN] = meter_val[M_TRIP_LEN] + n[31:0];
                     end
                     len_accum = acc[23:0];
                  end
                  last_pos = r.extruder_pos;
               end
               if (r.busy_req) begin
                  printing_st = 1'b1;
                  last_pos = r.extruder_pos;
                  len_accum = '0;
               end else begin
                  // busy-to-idle asks for a save
                  if (printing_st) save = 1'b1;
                  printing_st = 1'b0;
               end
            end
            if (save_dl < r.now_ms) begin
               save_dl = r.now_ms + save_period;
               save = 1'b1;
            end
         end
         CMD_TRIP: begin
            meter_val[M_TRIP_MIN] = '0;
            meter_val[M_TRIP_PMIN] = '0;
            meter_val[M_TRIP_LEN] = '0;
         end
         CMD_RESTORE: begin
            if (r.counter_index < NUM_METERS) meter_val[r.counter_index] = r.load_value;
         end
         default: begin
            save_dl = r.now_ms + save_period;
            minute_dl = r.now_ms + min_period;
            printing_st = 1'b0;
            last_pos = r.extruder_pos;
         end
      endcase
      rd.life_min = meter_val[M_LIFE_MIN];
      rd.life_pmin = meter_val[M_LIFE_PMIN];
      rd.life_len = meter_val[M_LIFE_LEN];
      rd.trip_min = meter_val[M_TRIP_MIN];
      rd.trip_pmin = meter_val[M_TRIP_PMIN];
      rd.trip_len = meter_val[M_TRIP_LEN];
      rd.printing = printing_st;
      rd.save_request = save;
      reading_q.push_back(rd);
   endtask

   function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                         input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   function automatic void queue_req(input logic [1:0] cmd, input logic [31:0] now_ms,
                                     input logic [31:0] pos, input logic [15:0] flow,
                                     input logic busy, input logic [2:0] idx,
                                     input logic [31:0] load);
      meter_req_t r;
      r.cmd = cmd;
      r.now_ms = now_ms;
      r.extruder_pos = pos;
      r.flow_scale = flow;
      r.busy_req = busy;
      r.counter_index = idx;
      r.load_value = load;
      pending_reqs.push_back(r);
   endfunction

   // Mostly samples that march time past the minute deadline with forward
   // extrusion; the rest are trip resets, restores, initialises and noise
   function automatic meter_req_t make_random_req();
      meter_req_t  r;
      int unsigned pick;
      logic [31:0] dt_ms;
      pick = $urandom_range(0, 99);
      r.cmd = CMD_SAMPLE;
      r.flow_scale = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(16'h0800, 16'h2000));
      r.busy_req = ($urandom_range(0, 4) != 0);
      r.counter_index = 3'($urandom_range(0, 7));
      r.load_value = $urandom;
      if (pick < 82) begin
         case ($urandom_range(0, 3))
            0: dt_ms = $urandom_range(0, min_period);
            1, 2: dt_ms = min_period + $urandom_range(0, 3);
            default: dt_ms = $urandom;
         endcase
         gen_time = gen_time + dt_ms;
         case ($urandom_range(0, 7))
            0: gen_pos = gen_pos - $urandom_range(0, 1000);
            1: gen_pos = $urandom;
            default: gen_pos = gen_pos + $urandom_range(1, limit_q);
         endcase
      end else if (pick < 86) begin
         r.cmd = CMD_TRIP;
      end else if (pick < 91) begin
         r.cmd = CMD_RESTORE;
      end else if (pick < 95) begin
         r.cmd = CMD_INIT;
      end
      r.now_ms = gen_time;
      r.extruder_pos = gen_pos;
      if (pick >= 95) begin
         r.cmd = 2'($urandom);
         r.now_ms = $urandom;
         r.extruder_pos = $urandom;
      end
      return r;
   endfunction

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_idx)
         REG_MINUTE: min_period = value;
         REG_SAVE: save_period = value;
         REG_LIMIT: limit_q = value[23:0];
         default: unit_q = value[23:0];
      endcase
   endtask

   // Hold until every request has been sent and answered
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_chan.valid || reading_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] minute_ms, input logic [31:0] save_ms,
                            input logic [23:0] limit, input logic [23:0] unit_len,
                            input int count);
      wait_drained();
      csr_write(REG_MINUTE, minute_ms);
      csr_write(REG_SAVE, save_ms);
      csr_write(REG_LIMIT, 32'(limit));
      csr_write(REG_UNIT, 32'(unit_len));
      queue_req(CMD_INIT, gen_time, gen_pos, FLOW_ONE, 1'b0, 3'd0, 32'd0);
      repeat (count) pending_reqs.push_back(make_random_req());
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) advance_meters(cur_req);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.cmd <= cur_req.cmd;
               req_chan.now_ms <= cur_req.now_ms;
               req_chan.extruder_pos <= cur_req.extruder_pos;
               req_chan.flow_scale <= cur_req.flow_scale;
               req_chan.busy_req <= cur_req.busy_req;
               req_chan.counter_index <= cur_req.counter_index;
               req_chan.load_value <= cur_req.load_value;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (reading_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp_reading = reading_q.pop_front();
               compare_field("life_minutes", exp_reading.life_min, rsp_chan.life_minutes);
               compare_field("life_print_minutes", exp_reading.life_pmin,
                             rsp_chan.life_print_minutes);
               compare_field("life_print_length", exp_reading.life_len,
                             rsp_chan.life_print_length);
               compare_field("trip_minutes", exp_reading.trip_min, rsp_chan.trip_minutes);
               compare_field("trip_print_minutes", exp_reading.trip_pmin,
                             rsp_chan.trip_print_minutes);
               compare_field("trip_print_length", exp_reading.trip_len,
                             rsp_chan.trip_print_length);
               compare_field("printing", 32'(exp_reading.printing), 32'(rsp_chan.printing));
               compare_field("save_request", 32'(exp_reading.save_request),
                             32'(rsp_chan.save_request));
            end
            rsp_count++;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         // One long hold-off so the pipeline fills and back-pressures requests
         if (!hold_done && rsp_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_chan.ready <= ($urandom_range(0, 4) < 2);
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_SAMPLE;
      req_chan.now_ms = '0;
      req_chan.extruder_pos = '0;
      req_chan.flow_scale = '0;
      req_chan.busy_req = 1'b0;
      req_chan.counter_index = '0;
      req_chan.load_value = '0;
      rsp_chan.ready = 1'b0;
      fail_count = 0;
      rsp_count = 0;
      cycle_count = 0;
      burst_left = 0;
      gap_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      stall_mode = 0;
      mode_left = 0;
      min_period = MINUTE_PERIOD_RST;
      save_period = SAVE_PERIOD_RST;
      limit_q = 24'(LIMIT_MM << FRAC_BITS_DEF);
      unit_q = 24'(UNIT_MM << FRAC_BITS_DEF);
      minute_dl = '0;
      save_dl = '0;
      last_pos = '0;
      len_accum = '0;
      printing_st = 1'b0;
      for (int i = 0; i < NUM_METERS; i++) meter_val[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: deadline equality, counting, busy-to-idle save, rejected
      // deltas, flow extremes, position and time extremes, restores, wraps
      queue_req(CMD_SAMPLE, 32'd0, 32'd0, FLOW_ONE, 1'b0, 3'd0, 32'd0);
      queue_req(CMD_INIT, 32'd1000, 32'd256, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd61000, 32'd256, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd61001, 32'd256, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd121001, 32'd8036, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd181001, 32'd10596, FLOW_ONE, 1'b0, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd241001, 32'd20000, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd301001, 32'd19000, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd361001, 32'd479800, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd421001, 32'd940599, 16'hFFFF, 1'b0, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd481001, 32'd940599, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd541001, 32'd941599, 16'h0000, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd601001, 32'h7FFFFFFF, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd661001, 32'h80000000, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'd721001, 32'h7FFFFFFF, 16'hFFFF, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'hFFFFFFFF, 32'h7FFFFFFF, FLOW_ONE, 1'b0, 3'd0, 32'd0);
      queue_req(CMD_TRIP, 32'd0, 32'd0, FLOW_ONE, 1'b0, 3'd0, 32'd0);
      for (int i = 0; i < NUM_METERS; i++)
         queue_req(CMD_RESTORE, 32'd0, 32'd0, FLOW_ONE, 1'b0, 3'(i), 32'hFFFFFFFF);
      queue_req(CMD_RESTORE, 32'd0, 32'd0, FLOW_ONE, 1'b0, 3'd6, 32'h12345678);
      queue_req(CMD_RESTORE, 32'd0, 32'd0, FLOW_ONE, 1'b0, 3'd7, 32'h0);
      queue_req(CMD_SAMPLE, 32'hFFFFFFFF, 32'h0, FLOW_ONE, 1'b1, 3'd0, 32'd0);
      queue_req(CMD_SAMPLE, 32'hFFFFFFFF, 32'd1000, FLOW_ONE, 1'b0, 3'd0, 32'd0);

      // Random traffic under a series of register settings
      gen_time = 32'd5000;
      gen_pos = 32'd0;
      queue_req(CMD_INIT, gen_time, gen_pos, FLOW_ONE, 1'b0, 3'd0, 32'd0);
      repeat (150) pending_reqs.push_back(make_random_req());
      run_phase(32'd1, 32'd1, 24'hFFFFFF, 24'd1, 150);
      run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 24'd1, 24'hFFFFFF, 100);
      run_phase(32'd1000, 32'd5000, 24'h010000, 24'd0, 100);
      repeat (4)
         run_phase($urandom_range(1, 200000), $urandom_range(1, 32'hFFFFFFFF),
                   24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 4096)), 110);
      wait_drained();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
